// ===== design/csv_field_splitter_macros.svh =====
// Assertion macros for the CSV field splitter.
// Each macro expects a signal named clk, and CSVFS_ASSERT also rst_n, in the scope where it is used.
`ifndef CSV_FIELD_SPLITTER_MACROS_SVH
`define CSV_FIELD_SPLITTER_MACROS_SVH

`ifndef SYNTHESIS
// A property that is checked on every clock edge outside reset.
`define CSVFS_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("csv_field_splitter assertion failed");
// A property that is also checked while reset is asserted.
`define CSVFS_ASSERT_ALWAYS(name, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("csv_field_splitter assertion failed");
`else
`define CSVFS_ASSERT(name, prop)
`define CSVFS_ASSERT_ALWAYS(name, prop)
`endif

`endif

// ===== design/csvfs_pkg.sv =====
package csvfs_pkg;

    // Depth of the store that holds inner whitespace of a field.
    localparam int PENDING_DEPTH = 16;
    localparam int ADDR_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CNT_W  = $clog2(PENDING_DEPTH + 1);

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_DELIMITER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_QUOTE     = 1'b1;
    localparam logic [7:0] RESET_DELIMITER = 8'd44;
    localparam logic [7:0] RESET_QUOTE     = 8'd34;

    // Input item codes.
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_EOL  = 1'b1;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_BYTE      = 2'd0,
        KIND_END_FIELD = 2'd1,
        KIND_END_LINE  = 2'd2
    } kind_t;

    // Role of one line byte.
    typedef enum logic [1:0] {
        CLS_QUOTE,
        CLS_DELIM,
        CLS_SPACE,
        CLS_TEXT
    } byte_class_t;

    // Latin-1 whitespace: tab to carriage return, space, NEL and no-break space.
    function automatic logic is_space(input logic [7:0] b);
        is_space = ((b >= 8'd9) && (b <= 8'd13)) || (b == 8'd32)
                   || (b == 8'h85) || (b == 8'hA0);
    endfunction

endpackage

// ===== design/csvfs_space_ram.sv =====
// Pending whitespace store: one write port, one read port, registered read data.
module csvfs_space_ram (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [csvfs_pkg::ADDR_W-1:0] wr_addr,
    input  logic [7:0]                  wr_data,
    input  logic                        rd_en,
    input  logic [csvfs_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                  rd_data
);

    logic [7:0] mem [csvfs_pkg::PENDING_DEPTH];
    logic [7:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/csvfs_classify.sv =====
// Sorts a line byte into quote, delimiter, whitespace or field text.
module csvfs_classify (
    input  logic                   byte_in,
    input  logic [7:0]             data,
    input  logic [7:0]             delimiter,
    input  logic [7:0]             quote,
    input  logic                   quoted,
    output csvfs_pkg::byte_class_t byte_class
);

    // A quote wins over the delimiter when both are the same byte; a delimiter
    // inside quotes is classed like any other byte. byte_in gates the result for end-of-line items.
    always_comb
    begin
        if (!byte_in)
        begin
            byte_class = csvfs_pkg::CLS_TEXT;
        end
        else if (data == quote)
        begin
            byte_class = csvfs_pkg::CLS_QUOTE;
        end
        else if ((data == delimiter) && !quoted)
        begin
            byte_class = csvfs_pkg::CLS_DELIM;
        end
        else if (csvfs_pkg::is_space(data))
        begin
            byte_class = csvfs_pkg::CLS_SPACE;
        end
        else
        begin
            byte_class = csvfs_pkg::CLS_TEXT;
        end
    end

endmodule

// ===== design/csv_field_splitter.sv =====
// CSV field splitter. Feed the bytes of a line (mode 0) and then one end-of-line beat
// (mode 1); fields come out as content bytes, each but the last closed by an end-of-field
// beat, and the line, if it held any byte, by an end-of-line beat, with quotes removed and
// outer whitespace trimmed. Each beat is first registered and then acted on; a beat that
// loads a result waits until the output register is free. A content byte is sent from a
// state of its own, after any held inner whitespace bytes, which are read back one at a
// time through the single read port of the pending whitespace memory. Up to 16 whitespace
// bytes are held per field; beyond that they are dropped and space_overflow is raised until
// the end of the line. The memory needs no clearing after reset. The input is taken while a
// result waits.
`include "csv_field_splitter_macros.svh"

module csv_field_splitter (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration writes.
    input  logic                           cfg_we,
    input  logic [csvfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    // Input channel.
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           mode,
    input  logic [7:0]                     in_byte,
    // Output channel.
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     out_byte,
    output logic [1:0]                     kind,
    output logic                           space_overflow,
    output logic                           last_of_run
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FLUSH,
        S_LAST
    } state_t;

    state_t                      state_reg,     state_next;
    logic [7:0]                  delim_reg,     delim_next;
    logic [7:0]                  quote_reg,     quote_next;
    logic                        mode_reg,      mode_next;
    logic [7:0]                  byte_reg,      byte_next;
    logic                        quoted_reg,    quoted_next;
    logic                        started_reg,   started_next;
    logic                        nonempty_reg,  nonempty_next;
    logic                        overflow_reg,  overflow_next;
    logic [csvfs_pkg::CNT_W-1:0] count_reg,     count_next;
    logic [csvfs_pkg::CNT_W-1:0] flush_idx_reg, flush_idx_next;
    logic                        out_valid_reg, out_valid_next;
    logic [7:0]                  out_byte_reg,  out_byte_next;
    csvfs_pkg::kind_t            kind_reg,      kind_next;
    logic                        out_ovf_reg,   out_ovf_next;
    logic                        last_reg,      last_next;

    logic                          out_free;
    logic                          ram_we;
    logic                          ram_re;
    logic [csvfs_pkg::ADDR_W-1:0]  ram_raddr;
    logic [7:0]                    ram_rd_data;
    csvfs_pkg::byte_class_t        byte_class;

    // Byte classification of the registered beat.
    csvfs_classify u_classify (
        .byte_in    (mode_reg == csvfs_pkg::MODE_BYTE),
        .data       (byte_reg),
        .delimiter  (delim_reg),
        .quote      (quote_reg),
        .quoted     (quoted_reg),
        .byte_class (byte_class)
    );

    // Pending whitespace store; writes and reads never overlap in time.
    csvfs_space_ram u_space_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (count_reg[csvfs_pkg::ADDR_W-1:0]),
        .wr_data (byte_reg),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rd_data)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    // Next-state logic: configuration, beat capture, field tracking and output loading.
    always_comb
    begin
        state_next     = state_reg;
        delim_next     = delim_reg;
        quote_next     = quote_reg;
        mode_next      = mode_reg;
        byte_next      = byte_reg;
        quoted_next    = quoted_reg;
        started_next   = started_reg;
        nonempty_next  = nonempty_reg;
        overflow_next  = overflow_reg;
        count_next     = count_reg;
        flush_idx_next = flush_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        kind_next      = kind_reg;
        out_ovf_next   = out_ovf_reg;
        last_next      = last_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = flush_idx_reg[csvfs_pkg::ADDR_W-1:0];

        if (cfg_we)
        begin
            unique case (cfg_index)
                csvfs_pkg::REG_DELIMITER: delim_next = cfg_data;
                csvfs_pkg::REG_QUOTE:     quote_next = cfg_data;
                default:                  ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = mode;
                    byte_next  = in_byte;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (mode_reg == csvfs_pkg::MODE_EOL)
                begin
                    if (!nonempty_reg || out_free)
                    begin
                        if (nonempty_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_byte_next  = 8'd0;
                            kind_next      = csvfs_pkg::KIND_END_LINE;
                            out_ovf_next   = overflow_reg;
                            last_next      = 1'b1;
                        end
                        quoted_next   = 1'b0;
                        started_next  = 1'b0;
                        nonempty_next = 1'b0;
                        overflow_next = 1'b0;
                        count_next    = '0;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    unique case (byte_class)
                        csvfs_pkg::CLS_QUOTE:
                        begin
                            quoted_next   = !quoted_reg;
                            nonempty_next = 1'b1;
                            state_next    = S_IDLE;
                        end
                        csvfs_pkg::CLS_DELIM:
                        begin
                            if (out_free)
                            begin
                                out_valid_next = 1'b1;
                                out_byte_next  = 8'd0;
                                kind_next      = csvfs_pkg::KIND_END_FIELD;
                                out_ovf_next   = overflow_reg;
                                last_next      = 1'b1;
                                started_next   = 1'b0;
                                count_next     = '0;
                                nonempty_next  = 1'b1;
                                state_next     = S_IDLE;
                            end
                        end
                        csvfs_pkg::CLS_SPACE:
                        begin
                            nonempty_next = 1'b1;
                            if (started_reg)
                            begin
                                if (count_reg < csvfs_pkg::CNT_W'(csvfs_pkg::PENDING_DEPTH))
                                begin
                                    ram_we     = 1'b1;
                                    count_next = count_reg + 1'b1;
                                end
                                else
                                begin
                                    overflow_next = 1'b1;
                                end
                            end
                            state_next = S_IDLE;
                        end
                        csvfs_pkg::CLS_TEXT:
                        begin
                            nonempty_next = 1'b1;
                            if (count_reg != '0)
                            begin
                                // Start reading the held whitespace from the first entry.
                                ram_re         = 1'b1;
                                ram_raddr      = '0;
                                flush_idx_next = csvfs_pkg::CNT_W'(1);
                                state_next     = S_FLUSH;
                            end
                            else
                            begin
                                state_next = S_LAST;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_FLUSH:
            begin
                // Send one held whitespace byte and fetch the next one.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = ram_rd_data;
                    kind_next      = csvfs_pkg::KIND_BYTE;
                    out_ovf_next   = overflow_reg;
                    last_next      = 1'b0;
                    if (flush_idx_reg == count_reg)
                    begin
                        state_next = S_LAST;
                    end
                    else
                    begin
                        ram_re         = 1'b1;
                        flush_idx_next = flush_idx_reg + 1'b1;
                    end
                end
            end

            S_LAST:
            begin
                // Send the content byte itself, which closes the run.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = byte_reg;
                    kind_next      = csvfs_pkg::KIND_BYTE;
                    out_ovf_next   = overflow_reg;
                    last_next      = 1'b1;
                    started_next   = 1'b1;
                    count_next     = '0;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // State, configuration and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            delim_reg     <= csvfs_pkg::RESET_DELIMITER;
            quote_reg     <= csvfs_pkg::RESET_QUOTE;
            quoted_reg    <= 1'b0;
            started_reg   <= 1'b0;
            nonempty_reg  <= 1'b0;
            overflow_reg  <= 1'b0;
            count_reg     <= '0;
            flush_idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            delim_reg     <= delim_next;
            quote_reg     <= quote_next;
            quoted_reg    <= quoted_next;
            started_reg   <= started_next;
            nonempty_reg  <= nonempty_next;
            overflow_reg  <= overflow_next;
            count_reg     <= count_next;
            flush_idx_reg <= flush_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Beat and result payload registers.
    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        byte_reg     <= byte_next;
        out_byte_reg <= out_byte_next;
        kind_reg     <= kind_next;
        out_ovf_reg  <= out_ovf_next;
        last_reg     <= last_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign kind           = kind_reg;
    assign space_overflow = out_ovf_reg;
    assign last_of_run    = last_reg;

    // The fill count never passes the depth of the store.
    `CSVFS_ASSERT(a_count_bound, count_reg <= csvfs_pkg::CNT_W'(csvfs_pkg::PENDING_DEPTH))
    // While flushing, the read pointer stays within the held bytes.
    `CSVFS_ASSERT(a_flush_range, (state_reg == S_FLUSH) |-> ((count_reg != '0) && (flush_idx_reg <= count_reg) && (flush_idx_reg != '0)))
    // Field and line ends carry a zero byte and always close their run.
    `CSVFS_ASSERT(a_end_beat, (out_valid && (kind != csvfs_pkg::KIND_BYTE)) |-> ((out_byte == 8'd0) && last_of_run))
    // An accepted beat is worked on before the next one is taken.
    `CSVFS_ASSERT(a_one_at_a_time, (in_valid && in_ready) |=> !in_ready)

endmodule
